FILE: hw/rtl/amd_pkg.sv
// Shared types and constants for the accelerometer motion detector.
// Used by every module of the block; no dependencies of its own.
`default_nettype none

package amd_pkg;

  // Number of axes the ports carry and the default number that is used.
  localparam int AXIS_MAX = 3;
  localparam int AXIS_COUNT_DEF = 3;

  // Field widths.
  localparam int INT_W = 9;
  localparam int MICRO_W = 21;
  localparam int MILLI_W = 19;
  localparam int DIFF_W = MILLI_W + 1;
  localparam int DELTA_W = 18;
  localparam int VLIM_W = 7;
  localparam int VOTE_W = 8;

  // Division of the micro magnitude by 1000 as a reciprocal multiply.
  // ceil(2^30 / 1000) is exact for every 21-bit magnitude.
  localparam int QUO_W = 11;
  localparam int RECIP_SHIFT = 30;
  localparam logic [MICRO_W-1:0] RECIP_1000 = MICRO_W'(1073742);
  localparam logic [MILLI_W-1:0] MILLI_PER_UNIT = MILLI_W'(1000);

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Configuration port.
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 18;
  localparam logic [CFG_IDX_W-1:0] REG_DELTA_LIMIT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_VOTE_LIMIT = CFG_IDX_W'(1);
  localparam logic [DELTA_W-1:0] DELTA_LIMIT_RST = DELTA_W'(500);
  localparam logic [VLIM_W-1:0] VOTE_LIMIT_RST = VLIM_W'(5);

  // Configuration register contents.
  typedef struct packed {
    logic [DELTA_W-1:0] delta_limit;
    logic [VLIM_W-1:0]  vote_limit;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic                     moving;
    logic signed [VOTE_W-1:0] vote_count;
    logic                     sample_moved;
    logic                     seeded_only;
  } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/amd_front.sv
// Front part of the motion detector: accepts sample items and converts each
// axis to milli units over two stages. Depends on amd_pkg.
`default_nettype none

module amd_front import amd_pkg::*; #(
  parameter int AXIS_COUNT = AXIS_COUNT_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic signed [INT_W-1:0]          int_part [AXIS_MAX],
  input  wire logic signed [MICRO_W-1:0]        micro_part [AXIS_MAX],
  output logic                                  push_valid,
  output logic [AXIS_COUNT-1:0][MILLI_W-1:0]    push_data,
  input  wire logic                             queue_full
);

  logic accept;
  logic push;
  logic vld_r, vld_nxt;

  // Per-axis stage registers: integer part scaled, quotient and its sign.
  logic [MILLI_W-1:0] int_milli_r [AXIS_COUNT];
  logic [QUO_W-1:0]   quo_r [AXIS_COUNT];
  logic               neg_r [AXIS_COUNT];

  // The stage holds one item; it moves on when the queue has room.
  assign in_stall = vld_r && queue_full;
  assign accept = in_valid && !in_stall;
  assign push = vld_r && !queue_full;
  assign push_valid = vld_r;

  always_comb begin
    vld_nxt = vld_r;
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (push) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  for (genvar k = 0; k < AXIS_COUNT; k++) begin : g_axis
    logic [MICRO_W-1:0]   mag;
    logic [2*MICRO_W-1:0] prod;
    logic [MILLI_W-1:0]   int_ext;
    logic [MILLI_W-1:0]   quo_ext;

    // Magnitude of the micro part, divided by 1000 through the reciprocal.
    assign mag = micro_part[k][MICRO_W-1] ? MICRO_W'(-micro_part[k])
                                          : MICRO_W'(micro_part[k]);
    assign prod = (2*MICRO_W)'(mag) * (2*MICRO_W)'(RECIP_1000);
    assign int_ext = MILLI_W'(int_part[k]);

    always_ff @(posedge clk) begin
      if (accept) begin
        int_milli_r[k] <= int_ext * MILLI_PER_UNIT;
        quo_r[k] <= prod[RECIP_SHIFT +: QUO_W];
        neg_r[k] <= micro_part[k][MICRO_W-1];
      end
    end

    // Second stage: add the signed quotient to the scaled integer part.
    assign quo_ext = MILLI_W'(quo_r[k]);
    assign push_data[k] = neg_r[k] ? int_milli_r[k] - quo_ext
                                   : int_milli_r[k] + quo_ext;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/amd_queue.sv
// Small register queue between the front and back parts of the motion
// detector. Depends on amd_pkg for its default depth.
`default_nettype none

module amd_queue import amd_pkg::*; #(
  parameter int WIDTH = MILLI_W,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  output logic                  pop_valid,
  output logic [WIDTH-1:0]      pop_data,
  input  wire logic             pop
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full = (cnt_r == FULL_CNT);
  assign pop_valid = (cnt_r != '0);
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push = push_valid && !full;
  assign do_pop = pop && pop_valid;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/amd_back.sv
// Back part of the motion detector: compares each item with the previous
// sample, runs the vote counter and holds the result register. Uses amd_pkg.
`default_nettype none

module amd_back import amd_pkg::*; #(
  parameter int AXIS_COUNT = AXIS_COUNT_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire cfg_t                          cfg,
  input  wire logic                          pop_valid,
  input  wire logic [AXIS_COUNT-1:0][MILLI_W-1:0] pop_data,
  output logic                               pop,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output result_t                            result
);

  logic primed_r;
  logic moving_r, moving_nxt;
  logic signed [VOTE_W-1:0] votes_r, votes_nxt;
  logic [MILLI_W-1:0] prev_r [AXIS_COUNT];
  logic out_valid_r, out_valid_nxt;
  result_t result_r, result_nxt;

  logic [AXIS_COUNT-1:0] exceed;
  logic moved;
  logic signed [VOTE_W:0] vote_step;
  logic signed [VOTE_W:0] lim_pos;
  logic signed [VOTE_W:0] lim_neg;

  // Take an item whenever the result register is free or being emptied.
  assign pop = pop_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign result = result_r;

  // Per-axis change against the stored previous value.
  for (genvar k = 0; k < AXIS_COUNT; k++) begin : g_axis
    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]        mag;

    assign diff = DIFF_W'($signed(pop_data[k])) - DIFF_W'($signed(prev_r[k]));
    assign mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    assign exceed[k] = (mag > DIFF_W'(cfg.delta_limit));

    always_ff @(posedge clk) begin
      if (pop) begin
        prev_r[k] <= pop_data[k];
      end
    end
  end

  assign moved = |exceed;

  // Vote counter and motion flag.
  assign vote_step = moved ? (VOTE_W+1)'(votes_r) + (VOTE_W+1)'(1)
                           : (VOTE_W+1)'(votes_r) - (VOTE_W+1)'(1);
  assign lim_pos = (VOTE_W+1)'(cfg.vote_limit);
  assign lim_neg = -lim_pos;

  always_comb begin
    moving_nxt = moving_r;
    votes_nxt = votes_r;
    result_nxt = result_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (pop) begin
      out_valid_nxt = 1'b1;
      if (primed_r) begin
        if (vote_step >= lim_pos) begin
          moving_nxt = 1'b1;
          votes_nxt = '0;
        end else if (vote_step <= lim_neg) begin
          moving_nxt = 1'b0;
          votes_nxt = '0;
        end else begin
          votes_nxt = VOTE_W'(vote_step);
        end
      end
      result_nxt.moving = moving_nxt;
      result_nxt.vote_count = votes_nxt;
      result_nxt.sample_moved = primed_r && moved;
      result_nxt.seeded_only = !primed_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primed_r <= 1'b0;
      moving_r <= 1'b0;
      votes_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        primed_r <= 1'b1;
      end
      moving_r <= moving_nxt;
      votes_r <= votes_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    result_r <= result_nxt;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/accel_motion_detector_top.sv
// Accelerometer motion detector: top level with the configuration registers.
// Instantiates amd_front, amd_queue and amd_back; uses amd_pkg.
//
// One item is one three-axis sample; each axis is turned into milli units,
// compared with the previous sample, and a signed vote counter decides the
// moving flag. The block takes one item per clock cycle while out_stall is low
// and gives exactly one result item per accepted item, in order. The
// accepting edge registers the reciprocal multiply that divides the micro
// part by 1000; then the two-entry queue is written, and then the compare
// and vote result is loaded into the output register, which drives
// out_valid. A full queue or out_stall can hold the item between these
// registers. The vote counter feeds back on itself through its register,
// which allows the rate of one item per cycle. The first item after reset
// only seeds the previous values. Configuration writes are always accepted
// and should only be made while no item is in flight.
`default_nettype none

module accel_motion_detector_top import amd_pkg::*; #(
  parameter int AXIS_COUNT = AXIS_COUNT_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic signed [INT_W-1:0]     in_x_int,
  input  wire logic signed [MICRO_W-1:0]   in_x_micro,
  input  wire logic signed [INT_W-1:0]     in_y_int,
  input  wire logic signed [MICRO_W-1:0]   in_y_micro,
  input  wire logic signed [INT_W-1:0]     in_z_int,
  input  wire logic signed [MICRO_W-1:0]   in_z_micro,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_moving,
  output logic signed [VOTE_W-1:0]         out_vote_count,
  output logic                             out_sample_moved,
  output logic                             out_seeded_only,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [CFG_DATA_W-1:0]       cfg_data
);

  localparam int ENTRY_W = AXIS_COUNT * MILLI_W;

  cfg_t cfg_r, cfg_nxt;
  result_t result;

  logic signed [INT_W-1:0]   int_part [AXIS_MAX];
  logic signed [MICRO_W-1:0] micro_part [AXIS_MAX];

  logic                              push_valid;
  logic [AXIS_COUNT-1:0][MILLI_W-1:0] push_data;
  logic                              queue_full;
  logic                              pop_valid;
  logic [ENTRY_W-1:0]                pop_data;
  logic                              pop;

  // Configuration registers: writes are always taken.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DELTA_LIMIT: cfg_nxt.delta_limit = cfg_data[DELTA_W-1:0];
        REG_VOTE_LIMIT:  cfg_nxt.vote_limit = cfg_data[VLIM_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delta_limit <= DELTA_LIMIT_RST;
      cfg_r.vote_limit <= VOTE_LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Gather the axis fields.
  assign int_part[0] = in_x_int;
  assign int_part[1] = in_y_int;
  assign int_part[2] = in_z_int;
  assign micro_part[0] = in_x_micro;
  assign micro_part[1] = in_y_micro;
  assign micro_part[2] = in_z_micro;

  amd_front #(
    .AXIS_COUNT(AXIS_COUNT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .int_part   (int_part),
    .micro_part (micro_part),
    .push_valid (push_valid),
    .push_data  (push_data),
    .queue_full (queue_full)
  );

  amd_queue #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .full       (queue_full),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop        (pop)
  );

  amd_back #(
    .AXIS_COUNT(AXIS_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result)
  );

  assign out_moving = result.moving;
  assign out_vote_count = result.vote_count;
  assign out_sample_moved = result.sample_moved;
  assign out_seeded_only = result.seeded_only;

endmodule

`default_nettype wire

FILE: hw/rtl/amd_checker.sv
// Port-level checks for the motion detector top level, and the bind that
// attaches them. Uses amd_pkg.
`default_nettype none

module amd_checker import amd_pkg::*; (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      out_valid,
  input wire logic                      out_stall,
  input wire logic                      out_moving,
  input wire logic signed [VOTE_W-1:0]  out_vote_count,
  input wire logic                      out_sample_moved,
  input wire logic                      out_seeded_only
);

  // A seeding item never reports motion.
  a_seed_no_motion: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_seeded_only |-> !out_sample_moved)
    else $error("seeding result reports motion");

  // The reported vote count never reaches -128, the most negative 8-bit value.
  a_vote_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_vote_count != -8'sd128)
    else $error("vote counter out of range");

  // No result is pending right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_vote_count)
      && $stable(out_moving) && $stable(out_seeded_only)
      && $stable(out_sample_moved))
    else $error("stalled result changed");

endmodule

bind accel_motion_detector_top amd_checker u_amd_checker (.*);

`default_nettype wire

FILE: verif/accel_motion_detector_top_test.sv
// Testbench for accel_motion_detector_top: directed and random accelerometer samples,
// with every motion report predicted in place and checked field by field.
// Depends on amd_pkg and accel_motion_detector_top only.
`timescale 1ns / 100ps

module accel_motion_detector_top_test;
  import amd_pkg::*;

  localparam int AXES = AXIS_COUNT_DEF;
  // Milli values reachable from any bit pattern of the integer and micro parts.
  localparam int MILLI_LO = -257048;
  localparam int MILLI_HI = 256048;
  localparam int MICRO_MAX = 1048575;
  localparam int INT_LO = -256;
  localparam int INT_HI = 255;
  // Register indexes that map to no register.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);
  // Settle time after the last report.
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic signed [INT_W-1:0]   x_int;
    logic signed [MICRO_W-1:0] x_micro;
    logic signed [INT_W-1:0]   y_int;
    logic signed [MICRO_W-1:0] y_micro;
    logic signed [INT_W-1:0]   z_int;
    logic signed [MICRO_W-1:0] z_micro;
  } sample_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [INT_W-1:0]    in_x_int = '0;
  logic signed [MICRO_W-1:0]  in_x_micro = '0;
  logic signed [INT_W-1:0]    in_y_int = '0;
  logic signed [MICRO_W-1:0]  in_y_micro = '0;
  logic signed [INT_W-1:0]    in_z_int = '0;
  logic signed [MICRO_W-1:0]  in_z_micro = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic                       out_moving;
  logic signed [VOTE_W-1:0]   out_vote_count;
  logic                       out_sample_moved;
  logic                       out_seeded_only;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;

  // Predicted detector state and register copies.
  int unsigned delta_lim = DELTA_LIMIT_RST;
  int unsigned vote_lim = VOTE_LIMIT_RST;
  int          prev_milli[AXES];
  bit          primed = 1'b0;
  int          votes = 0;
  bit          moving_state = 1'b0;

  result_t     motion_reports[$];
  int          fail_count = 0;
  int          tx_gap_pct = 0;
  int          rx_stall_pct = 0;

  accel_motion_detector_top u_dut (.*);

  // Clock.
  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  // Converts one axis to milli units; the division truncates toward zero.
  function automatic int to_milli(logic signed [INT_W-1:0] ip, logic signed [MICRO_W-1:0] mp);
    return int'(ip) * 1000 + int'(mp) / 1000;
  endfunction

  // Advances the detector state by one sample and returns its report.
  function automatic result_t predict_report(sample_t s);
    int      m[3];
    int      d;
    bit      moved;
    bit      seed;
    result_t r;
    m[0] = to_milli(s.x_int, s.x_micro);
    m[1] = to_milli(s.y_int, s.y_micro);
    m[2] = to_milli(s.z_int, s.z_micro);
    moved = 1'b0;
    seed = !primed;
    if (seed) begin
      for (int k = 0; k < AXES; k++) prev_milli[k] = m[k];
      primed = 1'b1;
    end else begin
      for (int k = 0; k < AXES; k++) begin
        d = m[k] - prev_milli[k];
        prev_milli[k] = m[k];
        if (d < 0) d = -d;
        if (d > int'(delta_lim)) moved = 1'b1;
      end
      votes += moved ? 1 : -1;
      if (votes >= int'(vote_lim)) begin
        moving_state = 1'b1;
        votes = 0;
      end else if (votes <= -int'(vote_lim)) begin
        moving_state = 1'b0;
        votes = 0;
      end
    end
    r.moving = moving_state;
    r.vote_count = VOTE_W'(votes);
    r.sample_moved = moved;
    r.seeded_only = seed;
    return r;
  endfunction

  // Idle lengths: mostly short, a few long.
  function automatic int gap_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) return $urandom_range(1, 3);
    if (pick < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Splits a milli value into integer and micro parts, varying the split and the
  // sub-milli digits so that the same value arrives in many encodings.
  function automatic void axis_parts(input int m, output logic signed [INT_W-1:0] ip,
                                     output logic signed [MICRO_W-1:0] mp);
    int whole;
    int cand;
    int rem;
    int spread;
    int pick;
    if (m < MILLI_LO) m = MILLI_LO;
    else if (m > MILLI_HI) m = MILLI_HI;
    whole = m / 1000;
    if (whole < INT_LO) whole = INT_LO;
    else if (whole > INT_HI) whole = INT_HI;
    cand = whole + (($urandom_range(0, 1) != 0) ? 1 : -1);
    rem = m - cand * 1000;
    if ($urandom_range(0, 3) == 0 && cand >= INT_LO && cand <= INT_HI
        && rem <= 1048 && rem >= -1048) whole = cand;
    rem = m - whole * 1000;
    spread = MICRO_MAX - (rem < 0 ? -rem : rem) * 1000;
    if (spread > 999) spread = 999;
    pick = $urandom_range(0, spread);
    if (rem > 0 || (rem == 0 && $urandom_range(0, 1) != 0)) mp = MICRO_W'(rem * 1000 + pick);
    else mp = MICRO_W'(rem * 1000 - pick);
    ip = INT_W'(whole);
  endfunction

  function automatic sample_t sample_from_milli(int mx, int my, int mz);
    sample_t s;
    axis_parts(mx, s.x_int, s.x_micro);
    axis_parts(my, s.y_int, s.y_micro);
    axis_parts(mz, s.z_int, s.z_micro);
    return s;
  endfunction

  // Any bit pattern at all, out-of-range parts included.
  function automatic sample_t random_pattern_sample();
    sample_t s;
    s.x_int = INT_W'($urandom());
    s.x_micro = MICRO_W'($urandom());
    s.y_int = INT_W'($urandom());
    s.y_micro = MICRO_W'($urandom());
    s.z_int = INT_W'($urandom());
    s.z_micro = MICRO_W'($urandom());
    return s;
  endfunction

  // Moves one axis by mag in a random direction, staying in the reachable range.
  function automatic int step_axis(int prev, int mag);
    int v;
    v = ($urandom_range(0, 1) != 0) ? prev + mag : prev - mag;
    if (v > MILLI_HI || v < MILLI_LO) v = 2 * prev - v;
    if (v > MILLI_HI) v = MILLI_HI;
    else if (v < MILLI_LO) v = MILLI_LO;
    return v;
  endfunction

  // Sends one item and records its predicted report once it is accepted.
  task automatic send_sample(sample_t s);
    in_valid <= 1'b1;
    in_x_int <= s.x_int;
    in_x_micro <= s.x_micro;
    in_y_int <= s.y_int;
    in_y_micro <= s.y_micro;
    in_z_int <= s.z_int;
    in_z_micro <= s.z_micro;
    do @(posedge clk); while (in_stall);
    motion_reports.push_back(predict_report(s));
    if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
  endtask

  // Stops sending and waits until every predicted report has come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (motion_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes one register; valid stays high into the next write unless this is the last.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data, bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (last) cfg_valid <= 1'b0;
    if (idx == REG_DELTA_LIMIT) delta_lim = data[DELTA_W-1:0];
    else if (idx == REG_VOTE_LIMIT) vote_lim = data[VLIM_W-1:0];
  endtask

  // Seeding with extreme parts, then the delta boundary and both vote thresholds
  // under the reset register values.
  task automatic test_seed_and_defaults();
    sample_t s;
    tx_gap_pct = 30;
    rx_stall_pct = 30;
    s.x_int = {1'b1, {(INT_W-1){1'b0}}};
    s.x_micro = {1'b1, {(MICRO_W-1){1'b0}}};
    s.y_int = {1'b0, {(INT_W-1){1'b1}}};
    s.y_micro = {1'b0, {(MICRO_W-1){1'b1}}};
    s.z_int = '0;
    s.z_micro = MICRO_W'(-999);
    send_sample(s);
    s.x_int = INT_W'(160);
    s.x_micro = MICRO_W'(-1000);
    s.y_int = INT_W'(-160);
    s.y_micro = MICRO_W'(999999);
    s.z_int = '0;
    s.z_micro = MICRO_W'(999);
    send_sample(s);
    // A change of exactly the limit is still; one more is motion.
    send_sample(sample_from_milli(prev_milli[0] + 500, prev_milli[1], prev_milli[2]));
    send_sample(sample_from_milli(prev_milli[0] + 501, prev_milli[1], prev_milli[2]));
    send_sample(sample_from_milli(prev_milli[0], prev_milli[1] - 501, prev_milli[2]));
    send_sample(sample_from_milli(prev_milli[0], prev_milli[1], prev_milli[2] - 500));
    // Enough motion to set the flag, then a run of stillness that does not yet clear it.
    repeat (5) send_sample(sample_from_milli(prev_milli[0], step_axis(prev_milli[1], 2000),
                                             prev_milli[2]));
    repeat (5) send_sample(sample_from_milli(prev_milli[0], prev_milli[1], prev_milli[2]));
  endtask

  // Register extremes: a zero delta with a zero vote limit, both at their maximum,
  // then both at one, and writes to indexes that hold no register.
  task automatic test_register_extremes();
    sample_t s;
    wait_idle();
    write_reg(REG_DELTA_LIMIT, '0, 1'b0);
    // Only the low bits reach the vote limit, so this writes zero.
    write_reg(REG_VOTE_LIMIT, CFG_DATA_W'(1 << VLIM_W), 1'b0);
    write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom()), 1'b0);
    write_reg(REG_SPARE_HI, '1, 1'b1);
    send_sample(sample_from_milli(prev_milli[0], prev_milli[1], prev_milli[2]));
    send_sample(sample_from_milli(prev_milli[0], prev_milli[1], prev_milli[2] + 1));
    send_sample(sample_from_milli(prev_milli[0], prev_milli[1], prev_milli[2]));
    wait_idle();
    write_reg(REG_DELTA_LIMIT, '1, 1'b0);
    write_reg(REG_VOTE_LIMIT, CFG_DATA_W'({VLIM_W{1'b1}}), 1'b1);
    send_sample(sample_from_milli(step_axis(prev_milli[0], 262143), prev_milli[1],
                                  prev_milli[2]));
    s = random_pattern_sample();
    s.x_int = {1'b1, {(INT_W-1){1'b0}}};
    s.x_micro = {1'b1, {(MICRO_W-1){1'b0}}};
    send_sample(s);
    s.x_int = {1'b0, {(INT_W-1){1'b1}}};
    s.x_micro = {1'b0, {(MICRO_W-1){1'b1}}};
    send_sample(s);
    wait_idle();
    write_reg(REG_DELTA_LIMIT, CFG_DATA_W'(1), 1'b0);
    write_reg(REG_VOTE_LIMIT, CFG_DATA_W'(1), 1'b1);
    send_sample(sample_from_milli(prev_milli[0] + 1, prev_milli[1], prev_milli[2]));
    send_sample(sample_from_milli(prev_milli[0], prev_milli[1] - 2, prev_milli[2]));
  endtask

  // One setting of the registers with runs of motion and stillness around the delta
  // boundary, most of them long enough to cross the vote thresholds, plus some raw noise.
  task automatic run_phase(int unsigned delta, int unsigned vote, int n_items, int tx_pct,
                           int rx_pct, bit drain_midway);
    int      sent;
    int      run_left;
    int      hit;
    int      mag;
    bit      motion_run;
    int      m[3];
    sample_t s;
    wait_idle();
    write_reg(REG_DELTA_LIMIT, CFG_DATA_W'(delta), 1'b0);
    write_reg(REG_VOTE_LIMIT, CFG_DATA_W'(($urandom() << VLIM_W) | (vote & 32'h7f)), 1'b1);
    tx_gap_pct = tx_pct;
    rx_stall_pct = rx_pct;
    sent = 0;
    run_left = 0;
    motion_run = 1'b0;
    while (sent < n_items) begin
      // Hold off until the block has drained completely.
      if (drain_midway && sent == n_items / 2) wait_idle();
      if ($urandom_range(0, 99) < 10) begin
        s = random_pattern_sample();
      end else begin
        if (run_left == 0) begin
          motion_run = $urandom_range(0, 1);
          if ($urandom_range(0, 99) < 60) run_left = int'(vote_lim) + $urandom_range(0, 3);
          else run_left = $urandom_range(1, vote_lim + 1);
        end
        hit = $urandom_range(0, AXES - 1);
        m[0] = prev_milli[0];
        m[1] = prev_milli[1];
        m[2] = prev_milli[2];
        for (int k = 0; k < AXES; k++) begin
          if (motion_run && k == hit) begin
            mag = int'(delta_lim) + 1;
            if ($urandom_range(0, 99) >= 30) mag += $urandom_range(0, 2000);
          end else if ($urandom_range(0, 99) < 25) begin
            mag = int'(delta_lim);
          end else begin
            mag = $urandom_range(0, delta_lim);
          end
          m[k] = step_axis(prev_milli[k], mag);
        end
        s = sample_from_milli(m[0], m[1], m[2]);
        run_left--;
      end
      send_sample(s);
      sent++;
    end
  endtask

  // Random traffic over several register settings and idling mixes.
  task automatic test_random_traffic();
    run_phase(DELTA_LIMIT_RST, VOTE_LIMIT_RST, 300, 0, 0, 1'b0);
    run_phase(0, 1, 250, 30, 30, 1'b0);
    run_phase($urandom_range(1, 5000), $urandom_range(2, 20), 300, 50, 50, 1'b1);
    run_phase(262143, 127, 200, 20, 10, 1'b0);
    run_phase($urandom_range(0, 262143), 0, 200, 10, 60, 1'b0);
    run_phase($urandom_range(0, 2000), $urandom_range(1, 127), 300, 40, 20, 1'b0);
    run_phase(1000, 3, 250, 5, 5, 1'b0);
  endtask

  // Receiver stalls of random length.
  initial begin
    forever begin
      @(posedge clk);
      if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
        out_stall <= 1'b1;
        repeat (gap_len()) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Compares each accepted report with the oldest prediction.
  always @(posedge clk) begin : check_reports
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (motion_reports.size() == 0) begin
        $error("report item with no sample pending");
        fail_count++;
      end else begin
        want = motion_reports.pop_front();
        if (out_moving !== want.moving) begin
          $error("moving: expected %0d, got %0d", want.moving, out_moving);
          fail_count++;
        end
        if (out_vote_count !== want.vote_count) begin
          $error("vote_count: expected %0d, got %0d", want.vote_count, out_vote_count);
          fail_count++;
        end
        if (out_sample_moved !== want.sample_moved) begin
          $error("sample_moved: expected %0d, got %0d", want.sample_moved, out_sample_moved);
          fail_count++;
        end
        if (out_seeded_only !== want.seeded_only) begin
          $error("seeded_only: expected %0d, got %0d", want.seeded_only, out_seeded_only);
          fail_count++;
        end
      end
    end
  end

  // Test sequence.
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_seed_and_defaults();
    test_register_extremes();
    test_random_traffic();
    wait_idle();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
